// File: hw/rtl/crpt_pkg.sv
// ============================================================================
// crpt_pkg - shared types and constants for the Catmull-Rom point/tangent unit
// Output field widths, saturation bounds and pipeline timing.
// ============================================================================
package crpt_pkg;

   localparam int POINT_WIDTH   = 18;
   localparam int TANGENT_WIDTH = 19;

   // two-stage multiplier, three of them in the point chain, plus a
   // coefficient level in front and an output level behind
   localparam int MUL_LATENCY  = 2;
   localparam int PIPE_LATENCY = 3 * MUL_LATENCY + 2;

   typedef logic signed [POINT_WIDTH-1:0]   point_type;
   typedef logic signed [TANGENT_WIDTH-1:0] tangent_type;

   localparam point_type   POINT_MAX   = {1'b0, {(POINT_WIDTH-1){1'b1}}};
   localparam point_type   POINT_MIN   = {1'b1, {(POINT_WIDTH-1){1'b0}}};
   localparam tangent_type TANGENT_MAX = {1'b0, {(TANGENT_WIDTH-1){1'b1}}};
   localparam tangent_type TANGENT_MIN = {1'b1, {(TANGENT_WIDTH-1){1'b0}}};

endpackage

// File: hw/rtl/crpt_mul.sv
// ============================================================================
// crpt_mul - pipelined signed-by-unsigned multiply-add
// p = x * t + addend, exact. x is split into two halves; the partial products
// are registered, then summed with the addend in the second stage.
// ============================================================================
module crpt_mul #(
   parameter int XW = 21,
   parameter int TW = 17,
   parameter int OW = 38
) (
   input  logic                 clock,
   input  logic signed [XW-1:0] x,
   input  logic        [TW-1:0] t,
   input  logic signed [OW-1:0] addend,
   output logic signed [OW-1:0] p
);

   localparam int LW = XW / 2;
   localparam int HW = XW - LW;

   logic        [LW-1:0]    x_lo;
   logic signed [HW-1:0]    x_hi;
   logic        [LW+TW-1:0] pp_lo_in, pp_lo_ff;
   logic signed [HW+TW-1:0] pp_hi_in, pp_hi_ff;
   logic signed [OW-1:0]    addend_ff;
   logic signed [OW-1:0]    sum_in, sum_ff;

   assign x_lo = x[LW-1:0];
   assign x_hi = $signed(x[XW-1:LW]);

   assign pp_lo_in = (LW+TW)'(x_lo) * (LW+TW)'(t);
   assign pp_hi_in = (HW+TW)'(x_hi) * (HW+TW)'($signed({1'b0, t}));

   always_ff @(posedge clock) begin
      pp_lo_ff  <= pp_lo_in;
      pp_hi_ff  <= pp_hi_in;
      addend_ff <= addend;
   end

   assign sum_in = (OW'(pp_hi_ff) <<< LW) + OW'($signed({1'b0, pp_lo_ff})) + addend_ff;

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign p = sum_ff;

endmodule

// File: hw/rtl/crpt_axis.sv
// ============================================================================
// crpt_axis - one axis of the Catmull-Rom evaluation
// Coefficients, Horner chains for point and tangent, rounding, saturation.
// Eight register levels lie between the inputs and pt / tg.
// ============================================================================
module crpt_axis #(
   parameter int COORD_WIDTH = 16,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic signed [COORD_WIDTH-1:0] q0,
   input  logic signed [COORD_WIDTH-1:0] q1,
   input  logic signed [COORD_WIDTH-1:0] q2,
   input  logic signed [COORD_WIDTH-1:0] q3,
   input  logic        [T_FRAC_BITS:0]   t,
   output crpt_pkg::point_type           pt,
   output crpt_pkg::tangent_type         tg
);

   localparam int F   = T_FRAC_BITS;
   localparam int TW  = T_FRAC_BITS + 1;
   localparam int AW  = COORD_WIDTH + 5;
   localparam int H1W = AW + TW;
   localparam int H2W = H1W + TW;
   localparam int H3W = H2W + TW;
   localparam int PVW = H3W - 3 * F - 1;
   localparam int TVW = H2W - 2 * F - 1;
   localparam int PEW = (PVW > crpt_pkg::POINT_WIDTH) ? PVW : crpt_pkg::POINT_WIDTH;
   localparam int TEW = (TVW > crpt_pkg::TANGENT_WIDTH) ? TVW : crpt_pkg::TANGENT_WIDTH;

   // ---- stage 1: polynomial coefficients ----
   logic signed [AW-1:0] q0e, q1e, q2e, q3e;
   logic signed [AW-1:0] a_in, a3_in, b_in, b2_in, c_in, d_in;
   logic signed [AW-1:0] a_ff, a3_ff, b_ff, b2_ff, c_ff, d_ff;
   logic signed [AW-1:0] c_pipe_ff [2:3];
   logic signed [AW-1:0] d_pipe_ff [2:5];
   logic        [TW-1:0] t_pipe_ff [1:5];

   assign q0e = AW'(q0);
   assign q1e = AW'(q1);
   assign q2e = AW'(q2);
   assign q3e = AW'(q3);

   assign a_in  = q3e - q0e + q1e + (q1e <<< 1) - q2e - (q2e <<< 1);
   assign b_in  = (q0e <<< 1) - q1e - (q1e <<< 2) + (q2e <<< 2) - q3e;
   assign a3_in = a_in + (a_in <<< 1);
   assign b2_in = b_in <<< 1;
   assign c_in  = q2e - q0e;
   assign d_in  = q1e <<< 1;

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      a3_ff <= a3_in;
      b_ff  <= b_in;
      b2_ff <= b2_in;
      c_ff  <= c_in;
      d_ff  <= d_in;
      t_pipe_ff[1] <= t;
      for (int i = 2; i <= 5; i++) begin
         t_pipe_ff[i] <= t_pipe_ff[i-1];
      end
      c_pipe_ff[2] <= c_ff;
      c_pipe_ff[3] <= c_pipe_ff[2];
      d_pipe_ff[2] <= d_ff;
      for (int i = 3; i <= 5; i++) begin
         d_pipe_ff[i] <= d_pipe_ff[i-1];
      end
   end

   // ---- Horner chains ----
   logic signed [H1W-1:0] h1, g1;
   logic signed [H2W-1:0] h2, g2;
   logic signed [H3W-1:0] h3;
   logic signed [H1W-1:0] add_h1, add_g1;
   logic signed [H2W-1:0] add_h2, add_g2;
   logic signed [H3W-1:0] add_h3;

   assign add_h1 = H1W'(b_ff) <<< F;
   assign add_g1 = H1W'(b2_ff) <<< F;
   assign add_h2 = H2W'(c_pipe_ff[3]) <<< (2 * F);
   // rounding half folded into the last addend of each chain
   assign add_g2 = (H2W'(c_pipe_ff[3]) + H2W'(1)) <<< (2 * F);
   assign add_h3 = (H3W'(d_pipe_ff[5]) + H3W'(1)) <<< (3 * F);

   crpt_mul #(.XW(AW), .TW(TW), .OW(H1W)) u_mul_h1 (
      .clock(clock), .x(a_ff), .t(t_pipe_ff[1]), .addend(add_h1), .p(h1)
   );
   crpt_mul #(.XW(AW), .TW(TW), .OW(H1W)) u_mul_g1 (
      .clock(clock), .x(a3_ff), .t(t_pipe_ff[1]), .addend(add_g1), .p(g1)
   );
   crpt_mul #(.XW(H1W), .TW(TW), .OW(H2W)) u_mul_h2 (
      .clock(clock), .x(h1), .t(t_pipe_ff[3]), .addend(add_h2), .p(h2)
   );
   crpt_mul #(.XW(H1W), .TW(TW), .OW(H2W)) u_mul_g2 (
      .clock(clock), .x(g1), .t(t_pipe_ff[3]), .addend(add_g2), .p(g2)
   );
   crpt_mul #(.XW(H2W), .TW(TW), .OW(H3W)) u_mul_h3 (
      .clock(clock), .x(h2), .t(t_pipe_ff[5]), .addend(add_h3), .p(h3)
   );

   // ---- round (shift) and saturate ----
   logic signed [PVW-1:0] pv;
   logic signed [TVW-1:0] tv;
   logic signed [PEW-1:0] pv_ext;
   logic signed [TEW-1:0] tv_ext;
   crpt_pkg::point_type   pt_in, pt_ff;
   crpt_pkg::tangent_type tg_in;
   crpt_pkg::tangent_type tg_pipe_ff [6:8];

   assign pv     = $signed(h3[H3W-1:3*F+1]);
   assign tv     = $signed(g2[H2W-1:2*F+1]);
   assign pv_ext = PEW'(pv);
   assign tv_ext = TEW'(tv);

   always_comb begin
      if (pv_ext > PEW'(crpt_pkg::POINT_MAX)) begin
         pt_in = crpt_pkg::POINT_MAX;
      end else if (pv_ext < PEW'(crpt_pkg::POINT_MIN)) begin
         pt_in = crpt_pkg::POINT_MIN;
      end else begin
         pt_in = pv_ext[crpt_pkg::POINT_WIDTH-1:0];
      end
   end

   always_comb begin
      if (tv_ext > TEW'(crpt_pkg::TANGENT_MAX)) begin
         tg_in = crpt_pkg::TANGENT_MAX;
      end else if (tv_ext < TEW'(crpt_pkg::TANGENT_MIN)) begin
         tg_in = crpt_pkg::TANGENT_MIN;
      end else begin
         tg_in = tv_ext[crpt_pkg::TANGENT_WIDTH-1:0];
      end
   end

   // tangent chain is two levels shorter: delay to line up with the point
   always_ff @(posedge clock) begin
      pt_ff         <= pt_in;
      tg_pipe_ff[6] <= tg_in;
      tg_pipe_ff[7] <= tg_pipe_ff[6];
      tg_pipe_ff[8] <= tg_pipe_ff[7];
   end

   assign pt = pt_ff;
   assign tg = tg_pipe_ff[8];

endmodule

// File: hw/rtl/catmull_rom_point_and_tangent_unit.sv
// ============================================================================
// catmull_rom_point_and_tangent_unit - uniform Catmull-Rom segment evaluator
// Point and tangent of one spline segment per clock, fully pipelined.
// ============================================================================
//
// A transfer takes place on every clock edge with start high outside reset;
// busy is high only while reset is asserted, as the pipeline never stalls.
// The result of each transfer appears on the rsp_ ports, in order, with
// rsp_strobe high for exactly one cycle; the receiver has no way to hold
// it off and must take it then. One item per clock is sustained; the
// pipeline depth is set by the Horner chain for the point: a coefficient
// stage, three multiply-adds of two stages each (the multiplicand is split
// into two partial products) and an output stage with rounding and
// saturation. param_t above 1.0 is treated as 1.0. Halves round towards
// plus infinity; values beyond the result fields saturate (only possible
// at wide coordinate settings).
//
module catmull_rom_point_and_tangent_unit #(
   parameter int COORD_WIDTH = 16,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_p0_x,
   input  logic signed [COORD_WIDTH-1:0] req_p0_y,
   input  logic signed [COORD_WIDTH-1:0] req_p1_x,
   input  logic signed [COORD_WIDTH-1:0] req_p1_y,
   input  logic signed [COORD_WIDTH-1:0] req_p2_x,
   input  logic signed [COORD_WIDTH-1:0] req_p2_y,
   input  logic signed [COORD_WIDTH-1:0] req_p3_x,
   input  logic signed [COORD_WIDTH-1:0] req_p3_y,
   input  logic        [T_FRAC_BITS:0]   req_param_t,
   output logic                          rsp_strobe,
   output crpt_pkg::point_type           rsp_point_x,
   output crpt_pkg::point_type           rsp_point_y,
   output crpt_pkg::tangent_type         rsp_tangent_x,
   output crpt_pkg::tangent_type         rsp_tangent_y
);

   localparam int LAT = crpt_pkg::PIPE_LATENCY;

   logic                 accept;
   logic [T_FRAC_BITS:0] t_clamped;
   logic [LAT-1:0]       valid_in, valid_ff;

   // no back-pressure anywhere; busy only keeps transfers out during reset
   assign busy   = reset;
   assign accept = start && !busy;

   // t above 1.0 has its top bit set with a non-zero fraction: clamp to 1.0
   assign t_clamped = req_param_t[T_FRAC_BITS]
                    ? {1'b1, {T_FRAC_BITS{1'b0}}}
                    : req_param_t;

   // valid bits travel alongside the data in the axis pipelines
   assign valid_in = {valid_ff[LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_strobe = valid_ff[LAT-1];

   crpt_axis #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_axis_x (
      .clock(clock),
      .q0(req_p0_x), .q1(req_p1_x), .q2(req_p2_x), .q3(req_p3_x),
      .t(t_clamped),
      .pt(rsp_point_x), .tg(rsp_tangent_x)
   );

   crpt_axis #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_axis_y (
      .clock(clock),
      .q0(req_p0_y), .q1(req_p1_y), .q2(req_p2_y), .q3(req_p3_y),
      .t(t_clamped),
      .pt(rsp_point_y), .tg(rsp_tangent_y)
   );

`ifndef SYNTHESIS
   // every transfer is followed by its result strobe once it has passed the pipeline
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(crpt_pkg::PIPE_LATENCY) rsp_strobe)
      else $error("result strobe missing after transfer");

   // no result strobe without a matching earlier transfer
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, crpt_pkg::PIPE_LATENCY))
      else $error("result strobe without matching transfer");
`endif

endmodule
